### rtl/cfd_pkg.sv
package cfd_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;
    localparam logic [7:0] CRC_POLY   = 8'h8C;

    localparam logic [2:0] PH_HUNT1 = 3'd0;
    localparam logic [2:0] PH_HUNT2 = 3'd1;
    localparam logic [2:0] PH_FUNC  = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CRC   = 3'd5;

    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] frame_func;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [7:0] payload_len;
        logic       crc_ok;
        logic       last;
    } t_result;

    // Reflected CRC-8 over one byte, eight shift steps unrolled.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/cfd_if.sv
interface cfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfd_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] frame_func;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [7:0] payload_len;
    logic       crc_ok;
    logic       last;

    modport source (output valid, output kind, output frame_func, output data_byte,
                    output byte_index, output payload_len, output crc_ok, output last,
                    input ready);
    modport sink   (input valid, input kind, input frame_func, input data_byte,
                    input byte_index, input payload_len, input crc_ok, input last,
                    output ready);
endinterface

### rtl/crc8_frame_deframer.sv
// Frame parser for a received byte stream: it hunts for the header 0xAA 0x55, then takes a
// function byte, a length byte, that many payload bytes and a CRC-8/MAXIM byte covering
// function, length and payload. Each payload byte leaves as an item tagged with function,
// index and length, and the CRC byte gives a frame-end item with crc_ok; frames with a bad
// CRC are still passed through and must be dropped downstream. One byte is taken in every
// cycle while the output does not stall, and a result appears in the cycle after its byte,
// held in an output register that still accepts a new byte in the cycle it is being read.
module crc8_frame_deframer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cfd_in_if.sink    i_rx,
    cfd_out_if.source o_res
);
    import cfd_pkg::*;

    logic    take;
    logic    res_valid;
    t_result res;
    logic    r_out_valid;
    t_result r_out;

    assign i_rx.ready = !r_out_valid || o_res.ready;
    assign take       = i_rx.valid && i_rx.ready;

    cfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (i_rx.rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_out.kind;
    assign o_res.frame_func  = r_out.frame_func;
    assign o_res.data_byte   = r_out.data_byte;
    assign o_res.byte_index  = r_out.byte_index;
    assign o_res.payload_len = r_out.payload_len;
    assign o_res.crc_ok      = r_out.crc_ok;
    assign o_res.last        = r_out.last;

endmodule

### rtl/cfd_parser.sv
module cfd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    output logic             o_res_valid,
    output cfd_pkg::t_result o_res
);
    import cfd_pkg::*;

    logic [2:0] r_phase;
    logic [2:0] n_phase;
    logic [7:0] r_func;
    logic [7:0] n_func;
    logic [7:0] r_len;
    logic [7:0] n_len;
    logic [7:0] r_count;
    logic [7:0] n_count;
    logic [7:0] r_crc;
    logic [7:0] n_crc;
    logic [7:0] crc_next;

    assign crc_next = crc8_step(r_crc, i_byte);

    always_comb begin
        n_phase     = r_phase;
        n_func      = r_func;
        n_len       = r_len;
        n_count     = r_count;
        n_crc       = r_crc;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.frame_func  = r_func;
        o_res.payload_len = r_len;
        case (r_phase)
            PH_HUNT2: begin
                if (i_byte == HDR_SECOND) begin
                    n_phase = PH_FUNC;
                end else if (i_byte == HDR_FIRST) begin
                    n_phase = PH_HUNT2;
                end else begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_FUNC: begin
                n_func  = i_byte;
                n_crc   = crc8_step(8'h00, i_byte);
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_len   = i_byte;
                n_crc   = crc_next;
                n_count = 8'h00;
                n_phase = (i_byte == 8'h00) ? PH_CRC : PH_DATA;
            end
            PH_DATA: begin
                o_res_valid      = 1'b1;
                o_res.kind       = KIND_PAYLOAD;
                o_res.data_byte  = i_byte;
                o_res.byte_index = r_count;
                n_crc            = crc_next;
                n_count          = r_count + 8'd1;
                if (n_count == r_len) begin
                    n_phase = PH_CRC;
                end
            end
            PH_CRC: begin
                o_res_valid  = 1'b1;
                o_res.kind   = KIND_FRAME_END;
                o_res.crc_ok = (i_byte == r_crc);
                o_res.last   = 1'b1;
                n_phase      = PH_HUNT1;
            end
            default: begin
                n_phase = (i_byte == HDR_FIRST) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
        if (!i_take) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT1;
            r_func  <= 8'h00;
            r_len   <= 8'h00;
            r_count <= 8'h00;
            r_crc   <= 8'h00;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_func  <= n_func;
            r_len   <= n_len;
            r_count <= n_count;
            r_crc   <= n_crc;
        end
    end

endmodule

### rtl/cfd_checker.sv
module cfd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_kind,
    input logic [7:0] i_data_byte,
    input logic [7:0] i_byte_index,
    input logic [7:0] i_payload_len,
    input logic       i_crc_ok,
    input logic       i_last
);

    // A waiting result is never overwritten: no byte is taken while the output stalls.
    a_no_take_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("byte taken while a result was stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result withdrawn before it was taken");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !(i_in_valid && i_in_ready)) |=> !i_out_valid)
        else $error("result repeated without a new byte");

    a_end_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_last) |-> (i_kind && i_data_byte == 8'h00 && i_byte_index == 8'h00))
        else $error("frame end with payload fields set");

    a_payload_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_kind) |-> (!i_last && !i_crc_ok && i_byte_index < i_payload_len))
        else $error("payload item outside its frame");

endmodule

bind crc8_frame_deframer cfd_checker u_cfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_rx.valid),
    .i_in_ready    (i_rx.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_kind        (o_res.kind),
    .i_data_byte   (o_res.data_byte),
    .i_byte_index  (o_res.byte_index),
    .i_payload_len (o_res.payload_len),
    .i_crc_ok      (o_res.crc_ok),
    .i_last        (o_res.last)
);
